// ----- sv/vcs_pkg.sv -----
// Shared types and codes for the vector cosine similarity block.
// No dependencies; only the top level imports this package.
package vcs_pkg;

  localparam int NUM_ELEMS  = 4;
  localparam int FIELD_BITS = 16;
  localparam int VALUE_BITS = 34;

  localparam logic [1:0] MODE_DOT = 2'd0;
  localparam logic [1:0] MODE_MAG = 2'd1;
  localparam logic [1:0] MODE_COS = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DIM  = 2'd1;
  localparam logic [1:0] ST_ZERO_MAG = 2'd2;

  localparam logic [2:0] DIM_MIN = 3'd2;
  localparam logic [2:0] DIM_MAX = 3'd4;

  typedef struct packed {
    logic [1:0]                   mode;
    logic [2:0]                   dim;
    logic signed [FIELD_BITS-1:0] a_0;
    logic signed [FIELD_BITS-1:0] a_1;
    logic signed [FIELD_BITS-1:0] a_2;
    logic signed [FIELD_BITS-1:0] a_3;
    logic signed [FIELD_BITS-1:0] b_0;
    logic signed [FIELD_BITS-1:0] b_1;
    logic signed [FIELD_BITS-1:0] b_2;
    logic signed [FIELD_BITS-1:0] b_3;
  } vcs_req_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [1:0]                   status;
  } vcs_rsp_t;

endpackage

// ----- sv/vcs_isqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband tag alongside; no package dependencies.
module vcs_isqrt #(
  parameter int PW = 66,
  parameter int TW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [PW-1:0]     in_rad,
  input  logic [TW-1:0]     in_tag,
  output logic              out_valid,
  output logic [PW/2-1:0]   out_root,
  output logic [TW-1:0]     out_tag
);

  localparam int RW = PW / 2;

  logic          vld  [1:RW];
  logic [PW-1:0] rad  [1:RW];
  logic [RW+1:0] rem  [1:RW];
  logic [RW-1:0] root [1:RW];
  logic [TW-1:0] tag  [1:RW];

  for (genvar s = 0; s < RW; s++) begin : g_step
    logic          src_vld;
    logic [PW-1:0] src_rad;
    logic [RW+1:0] src_rem;
    logic [RW-1:0] src_root;
    logic [TW-1:0] src_tag;
    logic [RW+1:0] rem_sh, trial, rem_n;
    logic          ge;

    if (s == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_rad  = in_rad;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_tag  = in_tag;
    end else begin : g_rest
      assign src_vld  = vld[s];
      assign src_rad  = rad[s];
      assign src_rem  = rem[s];
      assign src_root = root[s];
      assign src_tag  = tag[s];
    end

    // bring down the next two radicand bits and try root*4+1
    always_comb begin
      rem_sh = {src_rem[RW-1:0], src_rad[PW-1 -: 2]};
      trial  = {src_root, 2'b01};
      ge     = rem_sh >= trial;
      rem_n  = ge ? rem_sh - trial : rem_sh;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= src_vld;
      end
      rad[s+1]  <= src_rad << 2;
      rem[s+1]  <= rem_n;
      root[s+1] <= {src_root[RW-2:0], ge};
      tag[s+1]  <= src_tag;
    end
  end

  assign out_valid = vld[RW];
  assign out_root  = root[RW];
  assign out_tag   = tag[RW];

endmodule

// ----- sv/vcs_div.sv -----
// Pipelined restoring divider for a dividend no larger than the divisor:
// one integer bit then FB fraction bits, one bit per stage. No package use.
module vcs_div #(
  parameter int DW = 33,
  parameter int FB = 14,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [FB:0]   out_quo,
  output logic [DW-1:0] out_den,
  output logic [TW-1:0] out_tag
);

  localparam int NS = FB + 1;

  logic          vld [1:NS];
  logic [DW-1:0] rem [1:NS];
  logic [DW-1:0] den [1:NS];
  logic [FB:0]   quo [1:NS];
  logic [TW-1:0] tag [1:NS];

  for (genvar s = 0; s < NS; s++) begin : g_step
    logic          src_vld;
    logic [DW-1:0] src_rem, src_den;
    logic [FB:0]   src_quo;
    logic [TW-1:0] src_tag;
    logic [DW:0]   rem_sh, rem_n;
    logic          ge;

    if (s == 0) begin : g_first
      assign src_vld = in_valid;
      assign src_rem = in_num;
      assign src_den = in_den;
      assign src_quo = '0;
      assign src_tag = in_tag;
      assign rem_sh  = {1'b0, src_rem};
    end else begin : g_rest
      assign src_vld = vld[s];
      assign src_rem = rem[s];
      assign src_den = den[s];
      assign src_quo = quo[s];
      assign src_tag = tag[s];
      assign rem_sh  = {src_rem, 1'b0};
    end

    always_comb begin
      ge    = rem_sh >= {1'b0, src_den};
      rem_n = ge ? rem_sh - {1'b0, src_den} : rem_sh;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= src_vld;
      end
      rem[s+1] <= rem_n[DW-1:0];
      den[s+1] <= src_den;
      quo[s+1] <= {src_quo[FB-1:0], ge};
      tag[s+1] <= src_tag;
    end
  end

  assign out_valid = vld[NS];
  assign out_quo   = quo[NS];
  assign out_den   = den[NS];
  assign out_tag   = tag[NS];

endmodule

// ----- sv/vector_cosine_similarity.sv -----
// Top level: dot product, magnitude and fixed-point cosine of small vectors.
// Depends on vcs_pkg, vcs_isqrt and vcs_div.
//
//   channel   signals                 direction  meaning
//   request   start, busy, req        in         accepted when start & !busy
//   result    done, result            out        one-cycle strobe, no backpressure
//
// A request passes stages 1 to 4, the root pipeline (one bit per stage), the
// fraction divider and then the output register.
// A new request can enter every cycle; busy is tied low.
// Synchronous reset clears only the valid bits; data registers are not reset.
// Nothing stalls: results leave on done whether or not anyone looks.
module vector_cosine_similarity #(
  parameter int ELEM_BITS     = 16,
  parameter int COS_FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  vcs_pkg::vcs_req_t req,
  output logic             done,
  output vcs_pkg::vcs_rsp_t result
);
  import vcs_pkg::*;

  localparam int E   = ELEM_BITS;
  localparam int F   = COS_FRAC_BITS;
  localparam int PRW = 2 * E;          // one product
  localparam int SW  = 2 * E + 1;      // sum of squares
  localparam int DTW = 2 * E + 2;      // dot product, signed
  localparam int LO  = (SW + 1) / 2;   // low slice of ssb for split multiply
  localparam int HI  = SW - LO;
  localparam int PW  = 2 * SW;         // radicand
  localparam int TW  = 2 + 1 + 1 + DTW; // mode, bad dim, zero mag, dot
  localparam int LAT = 5 + SW + F + 1;

  assign busy = 1'b0;

  // ---- stage 1: fit fields to E bits, mask unused elements, per-element products
  logic signed [E-1:0] a_e [NUM_ELEMS];
  logic signed [E-1:0] b_e [NUM_ELEMS];
  logic [FIELD_BITS-1:0] a_raw [NUM_ELEMS];
  logic [FIELD_BITS-1:0] b_raw [NUM_ELEMS];
  logic bad_in;

  always_comb begin
    a_raw[0] = req.a_0; a_raw[1] = req.a_1; a_raw[2] = req.a_2; a_raw[3] = req.a_3;
    b_raw[0] = req.b_0; b_raw[1] = req.b_1; b_raw[2] = req.b_2; b_raw[3] = req.b_3;
    bad_in = (req.dim < DIM_MIN) || (req.dim > DIM_MAX);
    for (int i = 0; i < NUM_ELEMS; i++) begin
      // only the low E bits count; a wider E sees the field zero-extended
      if (3'(i) < req.dim) begin
        a_e[i] = E'(a_raw[i]);
        b_e[i] = E'(b_raw[i]);
      end else begin
        a_e[i] = '0;
        b_e[i] = '0;
      end
    end
  end

  logic                  v1, bad1;
  logic [1:0]            mode1;
  logic signed [PRW-1:0] pd1 [NUM_ELEMS];
  logic signed [PRW-1:0] pa1 [NUM_ELEMS];
  logic signed [PRW-1:0] pb1 [NUM_ELEMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    mode1 <= req.mode;
    bad1  <= bad_in;
    for (int i = 0; i < NUM_ELEMS; i++) begin
      pd1[i] <= a_e[i] * b_e[i];
      pa1[i] <= a_e[i] * a_e[i];
      pb1[i] <= b_e[i] * b_e[i];
    end
  end

  // ---- stage 2: sums
  logic                  v2, bad2;
  logic [1:0]            mode2;
  logic signed [DTW-1:0] dot2;
  logic [SW-1:0]         ssa2, ssb2;
  logic signed [DTW-1:0] dot_sum;
  logic [SW-1:0]         ssa_sum, ssb_sum;

  always_comb begin
    dot_sum = '0;
    ssa_sum = '0;
    ssb_sum = '0;
    for (int i = 0; i < NUM_ELEMS; i++) begin
      dot_sum = dot_sum + DTW'(pd1[i]);
      // squares are non-negative, so their bits read as unsigned
      ssa_sum = ssa_sum + SW'($unsigned(pa1[i]));
      ssb_sum = ssb_sum + SW'($unsigned(pb1[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    mode2 <= mode1;
    bad2  <= bad1;
    dot2  <= dot_sum;
    ssa2  <= ssa_sum;
    ssb2  <= ssb_sum;
  end

  // ---- stage 3: split ssa*ssb into two partial products, |dot|, zero check
  logic                  v3, bad3, zero3;
  logic [1:0]            mode3;
  logic signed [DTW-1:0] dot3;
  logic [SW-1:0]         ssa3, mag3;
  logic [SW+LO-1:0]      pp_lo3;
  logic [SW+HI-1:0]      pp_hi3;
  logic [DTW-1:0]        dot_abs;

  assign dot_abs = dot2[DTW-1] ? DTW'(-dot2) : DTW'(dot2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    mode3  <= mode2;
    bad3   <= bad2;
    zero3  <= (ssa2 == '0) || (ssb2 == '0);
    dot3   <= dot2;
    ssa3   <= ssa2;
    mag3   <= dot_abs[SW-1:0];
    pp_lo3 <= ssa2 * ssb2[LO-1:0];
    pp_hi3 <= ssa2 * ssb2[SW-1:LO];
  end

  // ---- stage 4: radicand (ssa alone for magnitude, ssa*ssb otherwise)
  logic          v4;
  logic [PW-1:0] rad4;
  logic [TW-1:0] tag4;
  logic [SW-1:0] mag4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    if (mode3 == MODE_MAG) begin
      rad4 <= PW'(ssa3);
    end else begin
      rad4 <= PW'(pp_lo3) + (PW'(pp_hi3) << LO);
    end
    tag4 <= {mode3, bad3, zero3, dot3};
    mag4 <= mag3;
  end

  // ---- root pipeline, then fraction divider
  logic             vr;
  logic [SW-1:0]    root_r;
  logic [SW+TW-1:0] tag_r;

  vcs_isqrt #(.PW(PW), .TW(SW + TW)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v4),
    .in_rad   (rad4),
    .in_tag   ({mag4, tag4}),
    .out_valid(vr),
    .out_root (root_r),
    .out_tag  (tag_r)
  );

  logic          vq;
  logic [F:0]    quo_q;
  logic [SW-1:0] root_q;
  logic [TW-1:0] tag_q;

  // |dot| <= root by Cauchy-Schwarz, so the quotient's integer part is 0 or 1
  vcs_div #(.DW(SW), .FB(F), .TW(TW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vr),
    .in_num   (tag_r[SW+TW-1:TW]),
    .in_den   (root_r),
    .in_tag   (tag_r[TW-1:0]),
    .out_valid(vq),
    .out_quo  (quo_q),
    .out_den  (root_q),
    .out_tag  (tag_q)
  );

  // ---- output stage: pick the result by mode
  logic [1:0]            mode_q;
  logic                  bad_q, zero_q;
  logic signed [DTW-1:0] dot_q;
  logic [F:0]            quo_sat;
  logic signed [VALUE_BITS-1:0] cos_mag, value_next;
  logic [1:0]            status_next;

  assign {mode_q, bad_q, zero_q, dot_q} = tag_q;

  always_comb begin
    // clamp is a guard only; the quotient never passes 1.0
    quo_sat = (quo_q > {1'b1, {F{1'b0}}}) ? {1'b1, {F{1'b0}}} : quo_q;
    cos_mag = VALUE_BITS'(quo_sat);
    value_next  = '0;
    status_next = ST_OK;
    if (bad_q) begin
      status_next = ST_BAD_DIM;
    end else begin
      unique case (mode_q)
        MODE_DOT: value_next = VALUE_BITS'(dot_q);
        MODE_MAG: value_next = VALUE_BITS'(root_q);
        MODE_COS: begin
          if (zero_q) begin
            status_next = ST_ZERO_MAG;
          end else begin
            value_next = dot_q[DTW-1] ? -cos_mag : cos_mag;
          end
        end
        default: value_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vq;
    end
    result.value  <= value_next;
    result.status <= status_next;
  end

  // ---- checks
  a_lat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a request LAT cycles back");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == ST_BAD_DIM) |-> result.value == '0)
    else $error("bad dimension with nonzero value");

  a_zmag_zero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == ST_ZERO_MAG) |-> result.value == '0)
    else $error("zero magnitude with nonzero value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_OK) || (result.status == ST_BAD_DIM) ||
             (result.status == ST_ZERO_MAG))
    else $error("undefined status code");

endmodule
